// File: design/gbss_pkg.sv
package gbss_pkg;

  localparam int NUM_CLASSES_DEF = 16;
  localparam int MAX_SAMPLES_DEF = 1048576;

  localparam int IDX_W  = 21;
  localparam int FEAT_W = 32;
  localparam int GAIN_W = 17;
  localparam int EPS_W  = 31;
  localparam int CFG_W  = 31;
  localparam int DIV_W  = 48;
  localparam int QUO_W  = 64;

  localparam logic [1:0] CFG_MIN_LEAF = 2'd0;
  localparam logic [1:0] CFG_FEAT_EPS = 2'd1;
  localparam logic [1:0] CFG_GAIN_EPS = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 17'd65536;

  typedef struct packed {
    logic                     req_type;
    logic signed [FEAT_W-1:0] feature;
    logic [3:0]               class_id;
    logic [11:0]              weight;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic                     split_valid;
    logic [IDX_W-1:0]         split_index;
    logic signed [FEAT_W-1:0] threshold;
    logic [GAIN_W-1:0]        best_gain;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_T_MUL0,
    OP_T_MUL1,
    OP_T_ACC,
    OP_S_FIRST,
    OP_S_UPD,
    OP_S_M1,
    OP_S_M2,
    OP_S_M3,
    OP_S_M4,
    OP_DIV_A,
    OP_DIV_B,
    OP_DIV_C,
    OP_DIV_G,
    OP_SUM,
    OP_CMP,
    OP_ADV,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    DSEL_A,
    DSEL_B,
    DSEL_C,
    DSEL_G
  } div_sel_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic req_type;
    logic last;
    logic tally_ok;
    logic scan_ok;
    logic scan_first;
    logic cand;
    logic l_zero;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// File: design/gbss_div.sv
module gbss_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       sat,
  input  logic [gbss_pkg::DIV_W-1:0] rem0,
  input  logic [gbss_pkg::QUO_W-1:0] bits,
  input  logic [gbss_pkg::DIV_W-1:0] dvsr,
  output logic                       done,
  output logic [gbss_pkg::QUO_W-1:0] quo
);

  localparam int RW = gbss_pkg::DIV_W;
  localparam int QW = gbss_pkg::QUO_W;
  localparam int STEPS = QW / 2;

  logic                        busy;
  logic [$clog2(STEPS)-1:0]    cnt;
  logic [RW-1:0]               rem;
  logic [QW-1:0]               sh;
  logic [RW-1:0]               d;
  logic [RW-1:0]               rem_next;
  logic [QW-1:0]               sh_next;

  // two restoring steps per cycle
  always_comb begin
    logic [RW:0] t;
    rem_next = rem;
    sh_next  = sh;
    for (int k = 0; k < 2; k++) begin
      t = {rem_next, sh_next[QW-1]};
      sh_next = {sh_next[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        rem_next = RW'(t - {1'b0, d});
        sh_next[0] = 1'b1;
      end else begin
        rem_next = t[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !sat;
        done <= sat;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(STEPS))'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem0;
      d   <= dvsr;
      sh  <= sat ? '1 : bits;
    end else if (busy) begin
      rem <= rem_next;
      sh  <= sh_next;
    end
  end

  assign quo = sh;

endmodule

// File: design/gbss_dp.sv
module gbss_dp #(
  parameter int NUM_CLASSES = gbss_pkg::NUM_CLASSES_DEF,
  parameter int MAX_SAMPLES = gbss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gbss_pkg::cmd_t             cmd,
  output gbss_pkg::status_t          status,
  input  gbss_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gbss_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [gbss_pkg::CFG_W-1:0] cfg_data
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IW    = gbss_pkg::IDX_W;
  localparam int FW    = gbss_pkg::FEAT_W;
  localparam int GW    = gbss_pkg::GAIN_W;
  localparam int RW    = gbss_pkg::DIV_W;
  localparam int QW    = gbss_pkg::QUO_W;

  // configuration
  logic [IW-1:0]                 msl;
  logic [gbss_pkg::EPS_W-1:0]    feps;
  logic [GW-1:0]                 geps;

  // current item
  logic                  it_req;
  logic signed [FW-1:0]  it_feat;
  logic [CLS_W-1:0]      it_cls;
  logic [11:0]           it_w;
  logic                  it_last;

  // class memories
  logic [31:0]           tot_mem  [NUM_CLASSES];
  logic [31:0]           left_mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] tot_vld;
  logic [NUM_CLASSES-1:0] left_vld;
  logic [31:0]           tot_q;
  logic [31:0]           left_q;
  logic [CLS_W-1:0]      rd_addr;

  // running sums
  logic [31:0]           tw;
  logic [31:0]           lw;
  logic [63:0]           tss;
  logic [63:0]           lss;
  logic [63:0]           rss;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      sidx;
  logic signed [FW-1:0]  pv_feat;
  logic [CLS_W-1:0]      pv_cls;
  logic [11:0]           pv_w;

  logic                  best_vld;
  logic [IW-1:0]         best_idx;
  logic [GW-1:0]         best_gain;
  logic signed [FW-1:0]  best_thr;

  logic [63:0]           preg;
  logic [31:0]           orr;
  logic [31:0]           nr;
  logic [QW-1:0]         a_q;
  logic [QW-1:0]         b_q;
  logic [QW-1:0]         c_q;
  logic [QW-1:0]         x_q;
  logic [GW-1:0]         g;
  gbss_pkg::div_sel_t    dsel;

  logic [CLS_W-1:0]      cls_in;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [31:0]           orr_c;
  logic [31:0]           rw_c;
  logic signed [FW:0]    fdiff;
  logic signed [FW:0]    tsum;
  logic signed [FW:0]    thalf;
  logic signed [FW-1:0]  thr_c;
  logic [64:0]           ab_sum;
  logic [63:0]           s_sat;
  logic                  better;

  logic                  div_start;
  logic                  div_sat;
  logic [RW-1:0]         div_rem0;
  logic [QW-1:0]         div_bits;
  logic [RW-1:0]         div_dvsr;
  logic                  div_done;
  logic [QW-1:0]         div_quo;

  always_comb begin
    if (9'(in_data.class_id) >= 9'(NUM_CLASSES)) begin
      cls_in = CLS_W'(NUM_CLASSES - 1);
    end else begin
      cls_in = CLS_W'(in_data.class_id);
    end
  end

  assign rd_addr = it_req ? pv_cls : it_cls;
  assign orr_c   = tot_q - left_q;
  assign rw_c    = tw - lw;

  always_comb begin
    case (cmd.op)
      gbss_pkg::OP_T_MUL0: begin
        mul_a = tot_q;
        mul_b = 32'(it_w);
      end
      gbss_pkg::OP_T_MUL1: begin
        mul_a = 32'(it_w);
        mul_b = 32'(it_w);
      end
      gbss_pkg::OP_S_UPD: begin
        mul_a = left_q;
        mul_b = 32'(pv_w);
      end
      gbss_pkg::OP_S_M1: begin
        mul_a = 32'(pv_w);
        mul_b = 32'(pv_w);
      end
      gbss_pkg::OP_S_M2: begin
        mul_a = orr;
        mul_b = orr;
      end
      gbss_pkg::OP_S_M3: begin
        mul_a = nr;
        mul_b = nr;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign fdiff = $signed({it_feat[FW-1], it_feat}) - $signed({pv_feat[FW-1], pv_feat});
  assign tsum  = $signed({it_feat[FW-1], it_feat}) + $signed({pv_feat[FW-1], pv_feat});
  assign thalf = tsum >>> 1;
  assign thr_c = (thalf[FW-1:0] == it_feat) ? pv_feat : $signed(thalf[FW-1:0]);

  assign ab_sum = {1'b0, a_q} + {1'b0, b_q};
  assign s_sat  = ab_sum[64] ? '1 : ab_sum[63:0];
  assign better = {1'b0, g} > ({1'b0, best_gain} + {1'b0, geps});

  always_comb begin
    div_start = 1'b0;
    div_sat   = 1'b0;
    div_rem0  = '0;
    div_bits  = '0;
    div_dvsr  = '0;
    case (cmd.op)
      gbss_pkg::OP_DIV_A: begin
        div_start = (lw != '0);
        div_sat   = lss[63:32] >= lw;
        div_rem0  = RW'(lss[63:32]);
        div_bits  = {lss[31:0], 32'd0};
        div_dvsr  = RW'(lw);
      end
      gbss_pkg::OP_DIV_B: begin
        div_start = 1'b1;
        div_sat   = rss[63:32] >= rw_c;
        div_rem0  = RW'(rss[63:32]);
        div_bits  = {rss[31:0], 32'd0};
        div_dvsr  = RW'(rw_c);
      end
      gbss_pkg::OP_DIV_C: begin
        div_start = 1'b1;
        div_sat   = tss[63:32] >= tw;
        div_rem0  = RW'(tss[63:32]);
        div_bits  = {tss[31:0], 32'd0};
        div_dvsr  = RW'(tw);
      end
      gbss_pkg::OP_DIV_G: begin
        div_start = 1'b1;
        div_bits  = x_q;
        div_dvsr  = {tw, 16'd0};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  gbss_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sat   (div_sat),
    .rem0  (div_rem0),
    .bits  (div_bits),
    .dvsr  (div_dvsr),
    .done  (div_done),
    .quo   (div_quo)
  );

  // class memories
  always_ff @(posedge clk) begin
    if (cmd.op == gbss_pkg::OP_READ) begin
      tot_q  <= tot_vld[rd_addr] ? tot_mem[rd_addr] : 32'd0;
      left_q <= left_vld[rd_addr] ? left_mem[rd_addr] : 32'd0;
    end
    if (cmd.op == gbss_pkg::OP_T_MUL0) begin
      tot_mem[it_cls] <= tot_q + 32'(it_w);
    end
    if (cmd.op == gbss_pkg::OP_S_UPD) begin
      left_mem[pv_cls] <= left_q + 32'(pv_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == gbss_pkg::OP_EMIT) begin
      tot_vld  <= '0;
      left_vld <= '0;
    end else begin
      if (cmd.op == gbss_pkg::OP_T_MUL0) begin
        tot_vld[it_cls] <= 1'b1;
      end
      if (cmd.op == gbss_pkg::OP_S_UPD) begin
        left_vld[pv_cls] <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      msl  <= IW'(1);
      feps <= '0;
      geps <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gbss_pkg::CFG_MIN_LEAF: msl  <= cfg_data[IW-1:0];
        gbss_pkg::CFG_FEAT_EPS: feps <= cfg_data[gbss_pkg::EPS_W-1:0];
        gbss_pkg::CFG_GAIN_EPS: geps <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // item and work registers
  always_ff @(posedge clk) begin
    if (cmd.op == gbss_pkg::OP_LOAD) begin
      it_req  <= in_data.req_type;
      it_feat <= in_data.feature;
      it_cls  <= cls_in;
      it_w    <= in_data.weight;
      it_last <= in_data.last;
    end
    if (cmd.op == gbss_pkg::OP_T_MUL0 || cmd.op == gbss_pkg::OP_T_MUL1 ||
        cmd.op == gbss_pkg::OP_S_UPD || cmd.op == gbss_pkg::OP_S_M1 ||
        cmd.op == gbss_pkg::OP_S_M2 || cmd.op == gbss_pkg::OP_S_M3) begin
      preg <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.op == gbss_pkg::OP_S_UPD) begin
      orr <= orr_c;
      nr  <= orr_c - 32'(pv_w);
    end
    if (cmd.op == gbss_pkg::OP_DIV_A && lw == '0) begin
      a_q <= '0;
    end
    if (div_start) begin
      case (cmd.op)
        gbss_pkg::OP_DIV_A: dsel <= gbss_pkg::DSEL_A;
        gbss_pkg::OP_DIV_B: dsel <= gbss_pkg::DSEL_B;
        gbss_pkg::OP_DIV_C: dsel <= gbss_pkg::DSEL_C;
        default:            dsel <= gbss_pkg::DSEL_G;
      endcase
    end
    if (div_done) begin
      case (dsel)
        gbss_pkg::DSEL_A: a_q <= div_quo;
        gbss_pkg::DSEL_B: b_q <= div_quo;
        gbss_pkg::DSEL_C: c_q <= div_quo;
        default: begin
          g <= (div_quo > QW'(gbss_pkg::GAIN_MAX)) ? gbss_pkg::GAIN_MAX :
                                                     div_quo[GW-1:0];
        end
      endcase
    end
    if (cmd.op == gbss_pkg::OP_SUM) begin
      x_q <= (s_sat > c_q) ? (s_sat - c_q) : '0;
    end
  end

  // node state
  always_ff @(posedge clk) begin
    if (rst || cmd.op == gbss_pkg::OP_EMIT) begin
      tw        <= '0;
      lw        <= '0;
      tss       <= '0;
      lss       <= '0;
      rss       <= '0;
      cnt       <= '0;
      sidx      <= '0;
      pv_feat   <= '0;
      pv_cls    <= '0;
      pv_w      <= '0;
      best_vld  <= 1'b0;
      best_idx  <= '0;
      best_gain <= '0;
      best_thr  <= '0;
    end else begin
      case (cmd.op)
        gbss_pkg::OP_T_MUL0: begin
          tw  <= tw + 32'(it_w);
          cnt <= cnt + 1'b1;
        end
        gbss_pkg::OP_T_MUL1: tss <= tss + {preg[62:0], 1'b0};
        gbss_pkg::OP_T_ACC:  tss <= tss + preg;
        gbss_pkg::OP_S_FIRST: rss <= tss;
        gbss_pkg::OP_S_UPD:  lw  <= lw + 32'(pv_w);
        gbss_pkg::OP_S_M1:   lss <= lss + {preg[62:0], 1'b0};
        gbss_pkg::OP_S_M2:   lss <= lss + preg;
        gbss_pkg::OP_S_M3:   rss <= rss - preg;
        gbss_pkg::OP_S_M4:   rss <= rss + preg;
        gbss_pkg::OP_CMP: begin
          best_vld <= 1'b1;
          if (better) begin
            best_idx  <= IW'(sidx);
            best_gain <= g;
            best_thr  <= thr_c;
          end
        end
        gbss_pkg::OP_ADV: begin
          pv_feat <= it_feat;
          pv_cls  <= it_cls;
          pv_w    <= it_w;
          sidx    <= sidx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == gbss_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gbss_pkg::OP_EMIT) begin
      out_data.split_valid <= best_vld;
      out_data.split_index <= best_idx;
      out_data.threshold   <= best_thr;
      out_data.best_gain   <= best_gain;
    end
  end

  always_comb begin
    status.req_type   = it_req;
    status.last       = it_last;
    status.tally_ok   = cnt < CNT_W'(MAX_SAMPLES);
    status.scan_ok    = sidx < CNT_W'(MAX_SAMPLES);
    status.scan_first = (sidx == '0);
    status.cand       = (lw < tw) && (fdiff > $signed({2'b00, feps})) &&
                        (22'(sidx) >= 22'(msl)) &&
                        ((22'(sidx) + 22'(msl)) <= 22'(cnt));
    status.l_zero     = (lw == '0);
    status.div_done   = div_done;
    status.out_busy   = out_valid && !out_ready;
  end

endmodule

// File: design/gbss_ctrl.sv
module gbss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output gbss_pkg::cmd_t    cmd,
  input  gbss_pkg::status_t status
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_T0, S_T1, S_T2, S_FIRST, S_UPD, S_M1, S_M2, S_M3, S_M4,
    S_CHK, S_DA, S_WA, S_DB, S_WB, S_DC, S_WC, S_SUM, S_DG, S_WG, S_CMP,
    S_ADV, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = gbss_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = gbss_pkg::OP_LOAD;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.op = gbss_pkg::OP_READ;
        if (!status.req_type) begin
          state_next = status.tally_ok ? S_T0 : S_IDLE;
        end else if (!status.scan_ok) begin
          state_next = status.last ? S_FIN : S_IDLE;
        end else begin
          state_next = status.scan_first ? S_FIRST : S_UPD;
        end
      end
      S_T0: begin
        cmd.op     = gbss_pkg::OP_T_MUL0;
        state_next = S_T1;
      end
      S_T1: begin
        cmd.op     = gbss_pkg::OP_T_MUL1;
        state_next = S_T2;
      end
      S_T2: begin
        cmd.op     = gbss_pkg::OP_T_ACC;
        state_next = S_IDLE;
      end
      S_FIRST: begin
        cmd.op     = gbss_pkg::OP_S_FIRST;
        state_next = S_ADV;
      end
      S_UPD: begin
        cmd.op     = gbss_pkg::OP_S_UPD;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.op     = gbss_pkg::OP_S_M1;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.op     = gbss_pkg::OP_S_M2;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.op     = gbss_pkg::OP_S_M3;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.op     = gbss_pkg::OP_S_M4;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = status.cand ? S_DA : S_ADV;
      end
      S_DA: begin
        cmd.op     = gbss_pkg::OP_DIV_A;
        state_next = status.l_zero ? S_DB : S_WA;
      end
      S_WA: begin
        if (status.div_done) begin
          state_next = S_DB;
        end
      end
      S_DB: begin
        cmd.op     = gbss_pkg::OP_DIV_B;
        state_next = S_WB;
      end
      S_WB: begin
        if (status.div_done) begin
          state_next = S_DC;
        end
      end
      S_DC: begin
        cmd.op     = gbss_pkg::OP_DIV_C;
        state_next = S_WC;
      end
      S_WC: begin
        if (status.div_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.op     = gbss_pkg::OP_SUM;
        state_next = S_DG;
      end
      S_DG: begin
        cmd.op     = gbss_pkg::OP_DIV_G;
        state_next = S_WG;
      end
      S_WG: begin
        if (status.div_done) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.op     = gbss_pkg::OP_CMP;
        state_next = S_ADV;
      end
      S_ADV: begin
        cmd.op     = gbss_pkg::OP_ADV;
        state_next = status.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.op     = gbss_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/gini_best_split_search.sv
// tally transfer: load, read and the tally states; first scan transfer: load, read, first, advance
// other scan transfers: load, read, update, the accumulate steps, check and advance
// scan transfer at a candidate boundary: adds up to four serial 64-bit quotients from one shared
// 2-bit-per-cycle divider; the last scan transfer then registers its result through the finish state,
// later only while an earlier result still waits for its transfer
// rst is synchronous: config returns to defaults and all node state clears at once
module gini_best_split_search #(
  parameter int NUM_CLASSES = gbss_pkg::NUM_CLASSES_DEF,
  parameter int MAX_SAMPLES = gbss_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gbss_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gbss_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [gbss_pkg::CFG_W-1:0] cfg_data
);

  gbss_pkg::cmd_t    cmd;
  gbss_pkg::status_t status;

  gbss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  gbss_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
